/* src/ucb_action_selector_macros.svh */
`ifndef UCB_ACTION_SELECTOR_MACROS_SVH
`define UCB_ACTION_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define UCB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCB_ASSERT_NOW(label, ante, cons, msg)
`define UCB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/ucb_pkg.sv */
package ucb_pkg;

    localparam int MAX_ACTIONS = 16;
    localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
    localparam int QDEPTH      = 2;

    localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SCORE_MIN = 32'h8000_0000;
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

    localparam logic [19:0] BIAS_FACTOR_RST = 20'd65536;
    localparam logic [30:0] MIN_BIAS_RST    = 31'd327680;

    localparam logic REG_BIAS_FACTOR = 1'b0;
    localparam logic REG_MIN_BIAS    = 1'b1;

    localparam int LOG_STEPS = 16;
    localparam int DIV_W     = 37;
    localparam int SQRT_STEPS = 19;

    typedef enum logic [1:0] {
        K_SKIP,
        K_ZERO,
        K_CALC
    } ucb_kind_t;

    typedef struct packed {
        logic [31:0] parent_value;
        logic [23:0] parent_visits;
        logic [31:0] child_value;
        logic [23:0] child_visits;
        logic [3:0]  child_index;
        logic        last;
        ucb_kind_t   kind;
    } ucb_entry_t;

    typedef struct packed {
        logic [19:0] bias_factor;
        logic [30:0] min_bias;
    } ucb_cfg_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_BIAS,
        B_LOG,
        B_LN,
        B_DIV,
        B_SQRT,
        B_TERM,
        B_SCORE,
        B_DONE
    } ucb_state_t;

endpackage

/* src/ucb_queue.sv */
module ucb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ucb_pkg::ucb_entry_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output ucb_pkg::ucb_entry_t rd_data,
    output logic               empty
);
    import ucb_pkg::*;
    `include "ucb_action_selector_macros.svh"

    ucb_entry_t mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'(QDEPTH));
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `UCB_ASSERT_NOW(a_no_overflow, wr_en, !full, "queue write while full")
    `UCB_ASSERT_NOW(a_no_underflow, rd_en, !empty, "queue read while empty")
    `UCB_ASSERT_NEXT(a_cnt_track, wr_en && !rd_en, cnt_reg == $past(cnt_reg) + 2'd1,
        "queue count did not advance on write")

endmodule

/* src/ucb_front.sv */
module ucb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        parent_value,
    input  logic [23:0]        parent_visits,
    input  logic [31:0]        child_value,
    input  logic [23:0]        child_visits,
    input  logic [3:0]         child_index,
    input  logic               last,
    input  logic               q_full,
    output logic               q_wr,
    output ucb_pkg::ucb_entry_t q_data
);
    import ucb_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             zero_seen_reg, zero_seen_next;
    logic             accept;
    logic             counted;
    logic             zero_vis;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign q_wr     = accept;
    assign counted  = (count_reg < CNT_W'(MAX_ACTIONS));
    assign zero_vis = (child_visits == 24'd0);

    always_comb
    begin
        q_data.parent_value  = parent_value;
        q_data.parent_visits = parent_visits;
        q_data.child_value   = child_value;
        q_data.child_visits  = child_visits;
        q_data.child_index   = child_index;
        q_data.last          = last;
        q_data.kind          = K_SKIP;
        if (counted && !zero_seen_reg)
        begin
            q_data.kind = zero_vis ? K_ZERO : K_CALC;
        end

        count_next     = count_reg;
        zero_seen_next = zero_seen_reg;
        if (accept)
        begin
            if (counted)
            begin
                count_next     = count_reg + CNT_W'(1);
                zero_seen_next = zero_seen_reg || zero_vis;
            end
            if (last)
            begin
                count_next     = '0;
                zero_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            zero_seen_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            zero_seen_reg <= zero_seen_next;
        end
    end

endmodule

/* src/ucb_back.sv */
module ucb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ucb_pkg::ucb_cfg_t  cfg,
    input  logic               q_empty,
    input  ucb_pkg::ucb_entry_t q_data,
    output logic               q_rd,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         best_index,
    output logic [31:0]        best_score,
    output logic               unvisited_pick
);
    import ucb_pkg::*;
    `include "ucb_action_selector_macros.svh"

    ucb_state_t  state_reg, state_next;
    ucb_entry_t  ent_reg, ent_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [30:0] bias_reg, bias_next;
    logic [30:0] y_reg, y_next;
    logic [20:0] log2_reg, log2_next;
    logic [23:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [37:0] res_reg, res_next;
    logic [DIV_W-1:0] sbit_reg, sbit_next;
    logic [33:0] term_reg, term_next;

    logic [31:0] run_score_reg, run_score_next;
    logic [3:0]  run_index_reg, run_index_next;
    logic        run_zero_reg, run_zero_next;
    logic        have_best_reg, have_best_next;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_index_reg, out_index_next;
    logic [31:0] out_score_reg, out_score_next;
    logic        out_zero_reg, out_zero_next;

    logic [31:0] apv;
    logic [51:0] bias_prod;
    logic [35:0] bias_shift;
    logic [30:0] bias_sat;
    logic [4:0]  top_bit;
    logic [61:0] sq;
    logic [52:0] ln_prod;
    logic [24:0] trial;
    logic [37:0] sum_rb;
    logic [49:0] term_prod;
    logic signed [35:0] score_wide;
    logic [31:0] score_sat;
    logic        out_free;

    assign empty          = !out_valid_reg;
    assign best_index     = out_index_reg;
    assign best_score     = out_score_reg;
    assign unvisited_pick = out_zero_reg;
    assign out_free       = !out_valid_reg || pop;

    always_comb
    begin
        apv        = ent_reg.parent_value[31] ? (~ent_reg.parent_value + 32'd1)
                                              : ent_reg.parent_value;
        bias_prod  = apv * 52'(cfg.bias_factor);
        bias_shift = bias_prod[51:16];
        bias_sat   = (|bias_shift[35:31]) ? SCORE_MAX[30:0] : bias_shift[30:0];
        if (bias_sat < cfg.min_bias)
        begin
            bias_sat = cfg.min_bias;
        end

        top_bit = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (ent_reg.parent_visits[i])
            begin
                top_bit = 5'(i);
            end
        end

        sq         = 62'(y_reg) * 62'(y_reg);
        ln_prod    = 53'(log2_reg) * 53'(LN2_Q32);
        trial      = {rem_reg, quo_reg[DIV_W-1]};
        sum_rb     = res_reg + 38'(sbit_reg);
        term_prod  = 50'(bias_reg) * 50'(res_reg[SQRT_STEPS-1:0]);
        score_wide = $signed({{4{ent_reg.child_value[31]}}, ent_reg.child_value})
                     + $signed({2'b00, term_reg});
        if (score_wide > $signed(36'(SCORE_MAX)))
        begin
            score_sat = SCORE_MAX;
        end
        else if (score_wide < $signed({{4{1'b1}}, SCORE_MIN}))
        begin
            score_sat = SCORE_MIN;
        end
        else
        begin
            score_sat = score_wide[31:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        cnt_next       = cnt_reg;
        bias_next      = bias_reg;
        y_next         = y_reg;
        log2_next      = log2_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_next       = res_reg;
        sbit_next      = sbit_reg;
        term_next      = term_reg;
        run_score_next = run_score_reg;
        run_index_next = run_index_reg;
        run_zero_next  = run_zero_reg;
        have_best_next = have_best_reg;
        out_valid_next = out_valid_reg && !pop;
        out_index_next = out_index_reg;
        out_score_next = out_score_reg;
        out_zero_next  = out_zero_reg;
        q_rd           = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd     = 1'b1;
                    ent_next = q_data;
                    case (q_data.kind)
                        K_CALC:
                        begin
                            state_next = B_BIAS;
                        end
                        K_ZERO:
                        begin
                            run_zero_next  = 1'b1;
                            have_best_next = 1'b1;
                            run_index_next = q_data.child_index;
                            run_score_next = SCORE_MAX;
                            state_next     = B_DONE;
                        end
                        default:
                        begin
                            state_next = B_DONE;
                        end
                    endcase
                end
            end
            B_BIAS:
            begin
                bias_next  = bias_sat;
                y_next     = 31'(31'(ent_reg.parent_visits) << (5'd30 - top_bit));
                log2_next  = {top_bit, 16'd0};
                cnt_next   = 6'(LOG_STEPS - 1);
                state_next = B_LOG;
            end
            B_LOG:
            begin
                if (sq[61])
                begin
                    y_next = sq[61:31];
                    log2_next[cnt_reg[3:0]] = 1'b1;
                end
                else
                begin
                    y_next = sq[60:30];
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = B_LN;
                end
            end
            B_LN:
            begin
                quo_next   = {ln_prod[52:32], 16'd0};
                rem_next   = 24'd0;
                cnt_next   = 6'(DIV_W - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (trial >= {1'b0, ent_reg.child_visits})
                begin
                    rem_next = 24'(trial - {1'b0, ent_reg.child_visits});
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[23:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    res_next   = 38'd0;
                    sbit_next  = {1'b1, {(DIV_W-1){1'b0}}};
                    cnt_next   = 6'(SQRT_STEPS - 1);
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if ({1'b0, quo_reg} >= sum_rb)
                begin
                    quo_next = DIV_W'({1'b0, quo_reg} - sum_rb);
                    res_next = (res_reg >> 1) + 38'(sbit_reg);
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = B_TERM;
                end
            end
            B_TERM:
            begin
                term_next  = term_prod[49:16];
                state_next = B_SCORE;
            end
            B_SCORE:
            begin
                if (!have_best_reg || ($signed(score_sat) > $signed(run_score_reg)))
                begin
                    have_best_next = 1'b1;
                    run_index_next = ent_reg.child_index;
                    run_score_next = score_sat;
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!ent_reg.last)
                begin
                    state_next = B_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = run_index_reg;
                    out_score_next = run_score_reg;
                    out_zero_next  = run_zero_reg;
                    run_score_next = SCORE_MIN;
                    run_index_next = 4'd0;
                    run_zero_next  = 1'b0;
                    have_best_next = 1'b0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            run_score_reg <= SCORE_MIN;
            run_index_reg <= 4'd0;
            run_zero_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_score_reg <= run_score_next;
            run_index_reg <= run_index_next;
            run_zero_reg  <= run_zero_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg       <= ent_next;
        cnt_reg       <= cnt_next;
        bias_reg      <= bias_next;
        y_reg         <= y_next;
        log2_reg      <= log2_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        res_reg       <= res_next;
        sbit_reg      <= sbit_next;
        term_reg      <= term_next;
        out_index_reg <= out_index_next;
        out_score_reg <= out_score_next;
        out_zero_reg  <= out_zero_next;
    end

    `UCB_ASSERT_NOW(a_unvisited_max, out_valid_reg && out_zero_reg, out_score_reg == SCORE_MAX,
        "unvisited pick without saturated score")
    `UCB_ASSERT_NEXT(a_emit_last, state_reg == B_DONE && ent_reg.last && out_free,
        out_valid_reg && !have_best_reg, "last request did not emit a result")
    `UCB_ASSERT_NOW(a_pop_idle_only, q_rd, state_reg == B_IDLE, "queue read while busy")

endmodule

/* src/ucb_action_selector.sv */
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------------
// request  | push / full        | parent_value parent_visits child_value child_visits
//          |                    | child_index last
// result   | pop / empty        | best_index best_score unvisited_pick
// config   | psel penable pwrite| paddr pwdata prdata (0x0 bias_factor, 0x4 min_bias)
//
// A scored request runs in the back end through 16 squaring steps for the logarithm,
// a restoring divider and a 19-step square root.
// Requests for unvisited, surplus or already-beaten children skip the arithmetic.
// A two-entry queue holds requests while the back end is busy; full rises when it fills.
// A result waits in the output register; a last request stalls only while it is occupied and not popped.
// Reset: asynchronous, active low; registers return to 1.0 and 5.0.
module ucb_action_selector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] parent_value,
    input  logic [23:0] parent_visits,
    input  logic [31:0] child_value,
    input  logic [23:0] child_visits,
    input  logic [3:0]  child_index,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  best_index,
    output logic [31:0] best_score,
    output logic        unvisited_pick,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ucb_pkg::*;

    logic [19:0] bias_factor_reg, bias_factor_next;
    logic [30:0] min_bias_reg, min_bias_next;
    ucb_cfg_t    cfg;
    logic        cfg_wr;
    logic        q_wr, q_rd, q_full, q_empty;
    ucb_entry_t  q_wdata, q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg.bias_factor = bias_factor_reg;
    assign cfg.min_bias    = min_bias_reg;
    assign prdata = (paddr[2] == REG_MIN_BIAS) ? {1'b0, min_bias_reg}
                                               : {12'd0, bias_factor_reg};

    always_comb
    begin
        bias_factor_next = bias_factor_reg;
        min_bias_next    = min_bias_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_BIAS_FACTOR:
                begin
                    bias_factor_next = pwdata[19:0];
                end
                REG_MIN_BIAS:
                begin
                    min_bias_next = pwdata[30:0];
                end
                default:
                begin
                    bias_factor_next = bias_factor_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_factor_reg <= BIAS_FACTOR_RST;
            min_bias_reg    <= MIN_BIAS_RST;
        end
        else
        begin
            bias_factor_reg <= bias_factor_next;
            min_bias_reg    <= min_bias_next;
        end
    end

    ucb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .parent_value  (parent_value),
        .parent_visits (parent_visits),
        .child_value   (child_value),
        .child_visits  (child_visits),
        .child_index   (child_index),
        .last          (last),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_data        (q_wdata)
    );

    ucb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    ucb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_rd           (q_rd),
        .empty          (empty),
        .pop            (pop),
        .best_index     (best_index),
        .best_score     (best_score),
        .unvisited_pick (unvisited_pick)
    );

endmodule

/* tb/ucb_action_selector_test.sv */
module ucb_action_selector_test;
    import ucb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] parent_value;
        logic [23:0] parent_visits;
        logic [31:0] child_value;
        logic [23:0] child_visits;
        logic [3:0]  child_index;
        logic        last;
    } child_req_t;

    typedef struct {
        logic [3:0]  best_index;
        logic [31:0] best_score;
        logic        unvisited_pick;
    } pick_t;

    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] parent_value = '0;
    logic [23:0] parent_visits = '0;
    logic [31:0] child_value = '0;
    logic [23:0] child_visits = '0;
    logic [3:0]  child_index = '0;
    logic        last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  best_index;
    logic [31:0] best_score;
    logic        unvisited_pick;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ucb_action_selector dut (.*);

    always #4 clk = ~clk;

    child_req_t  pending_reqs[$];
    pick_t       expected_picks[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          no_idling = 1'b0;
    bit          sender_hold = 1'b0;
    bit          timed_out = 1'b0;
    int          push_gap = 0;
    int          pop_gap = 0;

    logic [19:0] cur_bias_factor;
    logic [30:0] cur_min_bias;
    logic [31:0] best_so_far;
    logic [3:0]  best_idx_so_far;
    bit          unvisited_seen;
    bit          best_valid;
    int          children_seen;

    function automatic logic [63:0] natural_log_q16(logic [23:0] visits);
        logic [63:0] y;
        logic [63:0] log2v;
        int top;
        if (visits <= 1)
            return 0;
        top = 0;
        for (int b = 0; b < 24; b++)
            if (visits[b])
                top = b;
        y = 64'(visits) << (30 - top);
        log2v = 64'(top) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                log2v[i] = 1'b1;
            end
        end
        return 64'((128'(log2v) * 128'(LN2_Q32)) >> 32);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void clear_selection();
        best_so_far = SCORE_MIN;
        best_idx_so_far = '0;
        unvisited_seen = 1'b0;
        best_valid = 1'b0;
        children_seen = 0;
    endfunction

    function automatic void score_child(child_req_t r);
        longint signed pv;
        longint signed score;
        logic [63:0] apv;
        logic [63:0] bias;
        logic [63:0] ratio;
        logic [63:0] term;
        pick_t p;
        if (children_seen < MAX_ACTIONS)
        begin
            children_seen++;
            if (r.child_visits == 0)
            begin
                if (!unvisited_seen)
                begin
                    unvisited_seen = 1'b1;
                    best_valid = 1'b1;
                    best_idx_so_far = r.child_index;
                    best_so_far = SCORE_MAX;
                end
            end
            else if (!unvisited_seen)
            begin
                pv = longint'($signed(r.parent_value));
                apv = pv < 0 ? 64'(-pv) : 64'(pv);
                bias = (apv * 64'(cur_bias_factor)) >> 16;
                if (bias > 64'(SCORE_MAX))
                    bias = 64'(SCORE_MAX);
                if (bias < 64'(cur_min_bias))
                    bias = 64'(cur_min_bias);
                ratio = (natural_log_q16(r.parent_visits) << 16) / 64'(r.child_visits);
                term = (bias * floor_sqrt(ratio)) >> 16;
                score = longint'($signed(r.child_value)) + longint'(term);
                if (score > longint'(SCORE_MAX))
                    score = longint'(SCORE_MAX);
                if (score < -64'sd2147483648)
                    score = -64'sd2147483648;
                if (!best_valid || score > longint'($signed(best_so_far)))
                begin
                    best_valid = 1'b1;
                    best_idx_so_far = r.child_index;
                    best_so_far = score[31:0];
                end
            end
        end
        if (r.last)
        begin
            p.best_index = best_idx_so_far;
            p.best_score = best_so_far;
            p.unvisited_pick = unvisited_seen;
            expected_picks.push_back(p);
            clear_selection();
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
            begin
            end
            else if (pending_reqs.size() != 0 && !sender_hold &&
                     (push_gap == 0 || no_idling))
            begin
                child_req_t r;
                r = pending_reqs.pop_front();
                score_child(r);
                push <= 1'b1;
                parent_value <= r.parent_value;
                parent_visits <= r.parent_visits;
                child_value <= r.child_value;
                child_visits <= r.child_visits;
                child_index <= r.child_index;
                last <= r.last;
                if ($urandom_range(0, 5) == 0)
                    push_gap <= $urandom_range(1, 7);
            end
            else
            begin
                push <= 1'b0;
                if (push_gap > 0)
                    push_gap <= push_gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pop && !empty)
            begin
                if (expected_picks.size() == 0)
                begin
                    report_mismatch("unexpected request", 32'(best_index), '0);
                end
                else
                begin
                    pick_t e;
                    e = expected_picks.pop_front();
                    if (best_index !== e.best_index)
                        report_mismatch("best_index", 32'(best_index), 32'(e.best_index));
                    if (best_score !== e.best_score)
                        report_mismatch("best_score", best_score, e.best_score);
                    if (unvisited_pick !== e.unvisited_pick)
                        report_mismatch("unvisited_pick", 32'(unvisited_pick),
                                        32'(e.unvisited_pick));
                end
            end
            if (pop_gap > 0 && !no_idling)
            begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    pop_gap <= $urandom_range(1, 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0)
            cur_bias_factor = data[19:0];
        else if (addr == 3'd4)
            cur_min_bias = data[30:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || push || expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic child_req_t make_child(logic [31:0] pval, logic [23:0] pvis,
                                              logic [31:0] cval, logic [23:0] cvis,
                                              logic [3:0] idx, logic lst);
        child_req_t r;
        r.parent_value = pval;
        r.parent_visits = pvis;
        r.child_value = cval;
        r.child_visits = cvis;
        r.child_index = idx;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [23:0] rand_visits(bit allow_zero);
        case ($urandom_range(0, 5))
            0: return allow_zero ? 24'd0 : 24'd1;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1, 15));
            3: return 24'($urandom);
            default: return 24'($urandom_range(1, 5000));
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic queue_random_parent(int n);
        logic [31:0] pval;
        logic [23:0] pvis;
        pval = rand_value();
        pvis = rand_visits(1'b0);
        if ($urandom_range(0, 30) == 0)
            pvis = 24'd0;
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(make_child(
                $urandom_range(0, 9) == 0 ? rand_value() : pval,
                pvis, rand_value(),
                $urandom_range(0, 9) == 0 ? 24'd0 : rand_visits(1'b0),
                4'($urandom), k == n - 1));
    endtask

    initial
    begin
        int sent;
        cur_bias_factor = BIAS_FACTOR_RST;
        cur_min_bias = MIN_BIAS_RST;
        clear_selection();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        pending_reqs.push_back(make_child(32'h0001_0000, 24'd10, 32'h0000_8000,
                                          24'd3, 4'd0, 1'b1));
        pending_reqs.push_back(make_child(32'h8000_0000, 24'hFFFFFF, 32'h8000_0000,
                                          24'd1, 4'd15, 1'b0));
        pending_reqs.push_back(make_child(32'h7FFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF,
                                          24'hFFFFFF, 4'd3, 1'b0));
        pending_reqs.push_back(make_child(32'h7FFF_FFFF, 24'hFFFFFF, 32'h7FFF_FFFF,
                                          24'hFFFFFF, 4'd4, 1'b1));
        pending_reqs.push_back(make_child(32'h0, 24'd1, 32'h0001_0000, 24'd5, 4'd1, 1'b0));
        pending_reqs.push_back(make_child(32'h0, 24'd1, 32'h0001_0000, 24'd5, 4'd2, 1'b0));
        pending_reqs.push_back(make_child(32'h0, 24'd0, 32'h0, 24'd0, 4'd7, 1'b0));
        pending_reqs.push_back(make_child(32'h0, 24'd0, 32'h0, 24'd0, 4'd8, 1'b0));
        pending_reqs.push_back(make_child(32'h0, 24'd50, 32'h7FFF_FFFF, 24'd1, 4'd9, 1'b1));
        for (int k = 0; k < 18; k++)
            pending_reqs.push_back(make_child(32'hFFFF_0000, 24'd100, 32'(k << 16),
                                              24'd2, 4'(k), k == 17));
        wait_drained();

        write_reg(3'd0, 32'hF_FFFF);
        write_reg(3'd4, 32'h0);
        for (int p = 0; p < 60; p++)
            queue_random_parent($urandom_range(1, 6));
        wait_drained();

        write_reg(3'd0, 32'h0);
        write_reg(3'd4, 32'h7FFF_FFFF);
        for (int p = 0; p < 60; p++)
            queue_random_parent($urandom_range(1, 6));
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(3'd0, $urandom);
            write_reg(3'd4, $urandom);
            sender_hold <= 1'b0;
            for (int p = 0; p < 90; p++)
            begin
                int n;
                n = $urandom_range(0, 15) == 0 ? $urandom_range(15, 19) :
                    $urandom_range(1, 5);
                if ($urandom_range(0, 12) == 0)
                    pending_reqs.push_back(make_child($urandom, 24'($urandom), $urandom,
                                                      24'($urandom), 4'($urandom), 1'b1));
                else
                    queue_random_parent(n);
            end
            if (phase == 1)
            begin
                while (pending_reqs.size() > 150)
                    @(posedge clk);
                sender_hold <= 1'b1;
                while (push || expected_picks.size() != 0)
                    @(posedge clk);
                sender_hold <= 1'b0;
            end
            if (phase == 3)
                no_idling <= 1'b1;
            wait_drained();
        end

        write_reg(3'd0, 32'(BIAS_FACTOR_RST));
        write_reg(3'd4, 32'(MIN_BIAS_RST));
        for (int p = 0; p < 20; p++)
            queue_random_parent($urandom_range(1, 4));
        wait_drained();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
